// ----- hw/rtl/dsrm_pkg.sv -----
`timescale 1ns / 1ps
package dsrm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_IDX_W     = 2;
    localparam int REG_W         = 32;

    typedef enum logic [1:0] {
        MODE_FIXED   = 2'd0,
        MODE_RADIUS  = 2'd1,
        MODE_SURFACE = 2'd2,
        MODE_VOLUME  = 2'd3
    } t_mode;

    localparam logic [REG_IDX_W-1:0] REG_MAP_MODE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_RADIUS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RADIUS = 2'd3;

    localparam logic [REG_W-1:0] SCALE_RST = 32'h0001_0000;
    localparam logic [REG_W-1:0] MIN_RST   = 32'h0000_0000;
    localparam logic [REG_W-1:0] MAX_RST   = 32'hFFFF_FFFF;

endpackage

// ----- hw/rtl/dsrm_cell.sv -----
`timescale 1ns / 1ps
// One digit of the square root and one digit of the cube root per cell, each only where DO_SQ or DO_CB is set.
module dsrm_cell #(
    parameter int NS    = 24,
    parameter int NC    = 21,
    parameter bit DO_SQ = 1'b1,
    parameter bit DO_CB = 1'b1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_neg,
    input  logic [30:0]       i_mag,
    input  logic [2*NS-1:0]   i_xs,
    input  logic [NS-1:0]     i_ys,
    input  logic [NS+1:0]     i_rs,
    input  logic [3*NC-1:0]   i_xc,
    input  logic [NC-1:0]     i_yc,
    input  logic [2*NC-1:0]   i_sc,
    input  logic [2*NC+3:0]   i_rc,
    output logic              o_neg,
    output logic [30:0]       o_mag,
    output logic [2*NS-1:0]   o_xs,
    output logic [NS-1:0]     o_ys,
    output logic [NS+1:0]     o_rs,
    output logic [3*NC-1:0]   o_xc,
    output logic [NC-1:0]     o_yc,
    output logic [2*NC-1:0]   o_sc,
    output logic [2*NC+3:0]   o_rc
);

    localparam int RS = NS + 2;
    localparam int RC = 2 * NC + 4;

    logic [RS-1:0]     s_cand, s_t;
    logic              s_ok;
    logic [RC-1:0]     c_cand, c_t, c_s, c_y;
    logic              c_ok;

    logic [2*NS-1:0]   n_xs;
    logic [NS-1:0]     n_ys;
    logic [RS-1:0]     n_rs;
    logic [3*NC-1:0]   n_xc;
    logic [NC-1:0]     n_yc;
    logic [2*NC-1:0]   n_sc;
    logic [RC-1:0]     n_rc;

    logic              r_neg;
    logic [30:0]       r_mag;
    logic [2*NS-1:0]   r_xs;
    logic [NS-1:0]     r_ys;
    logic [RS-1:0]     r_rs;
    logic [3*NC-1:0]   r_xc;
    logic [NC-1:0]     r_yc;
    logic [2*NC-1:0]   r_sc;
    logic [RC-1:0]     r_rc;

    always_comb begin
        // square root: bring down two bits, try 4y+1
        s_cand = {i_rs[RS-3:0], i_xs[2*NS-1 -: 2]};
        s_t    = {i_ys, 2'b01};
        s_ok   = (s_cand >= s_t);
        n_xs   = i_xs;
        n_ys   = i_ys;
        n_rs   = i_rs;
        if (DO_SQ) begin
            n_xs = {i_xs[2*NS-3:0], 2'b00};
            n_ys = {i_ys[NS-2:0], s_ok};
            n_rs = s_ok ? (s_cand - s_t) : s_cand;
        end
        // cube root: bring down three bits, try 12*y^2 + 6*y + 1
        c_cand = {i_rc[RC-4:0], i_xc[3*NC-1 -: 3]};
        c_s    = {{(RC-2*NC){1'b0}}, i_sc};
        c_y    = {{(RC-NC){1'b0}}, i_yc};
        c_t    = (c_s << 3) + (c_s << 2) + (c_y << 2) + (c_y << 1) + {{(RC-1){1'b0}}, 1'b1};
        c_ok   = (c_cand >= c_t);
        n_xc   = i_xc;
        n_yc   = i_yc;
        n_sc   = i_sc;
        n_rc   = i_rc;
        if (DO_CB) begin
            n_xc = {i_xc[3*NC-4:0], 3'b000};
            n_yc = {i_yc[NC-2:0], c_ok};
            n_rc = c_ok ? (c_cand - c_t) : c_cand;
            n_sc = c_ok ? ((i_sc << 2) + ({{NC{1'b0}}, i_yc} << 2)
                           + {{(2*NC-1){1'b0}}, 1'b1})
                        : (i_sc << 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_neg;
            r_mag <= i_mag;
            r_xs  <= n_xs;
            r_ys  <= n_ys;
            r_rs  <= n_rs;
            r_xc  <= n_xc;
            r_yc  <= n_yc;
            r_sc  <= n_sc;
            r_rc  <= n_rc;
        end
    end

    assign o_neg = r_neg;
    assign o_mag = r_mag;
    assign o_xs  = r_xs;
    assign o_ys  = r_ys;
    assign o_rs  = r_rs;
    assign o_xc  = r_xc;
    assign o_yc  = r_yc;
    assign o_sc  = r_sc;
    assign o_rc  = r_rc;

endmodule

// ----- hw/rtl/dsrm_post.sv -----
`timescale 1ns / 1ps
// Scale multiply, then truncate, saturate and clamp.
module dsrm_post #(
    parameter int FRAC_BITS = 16,
    parameter int NS        = 24,
    parameter int NC        = 21
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  dsrm_pkg::t_mode   i_mode,
    input  logic [31:0]       i_scale,
    input  logic [31:0]       i_min,
    input  logic [31:0]       i_max,
    input  logic              i_neg,
    input  logic [30:0]       i_mag,
    input  logic [NS-1:0]     i_sq,
    input  logic [NC-1:0]     i_cb,
    output logic [31:0]       o_radius,
    output logic              o_inv
);

    logic [31:0] opnd;
    logic        inv;
    logic [63:0] n_prod;
    logic [63:0] r_prod;
    logic        r_inv;
    logic        sat;
    logic [63:0] shifted;
    logic [31:0] res;
    logic [31:0] r_radius;
    logic        r_oinv;

    always_comb begin
        inv = 1'b0;
        case (i_mode)
            dsrm_pkg::MODE_FIXED:   opnd = 32'd1 << FRAC_BITS;
            dsrm_pkg::MODE_RADIUS:  opnd = i_neg ? 32'd0 : {1'b0, i_mag};
            dsrm_pkg::MODE_SURFACE: begin
                opnd = {{(32-NS){1'b0}}, i_sq};
                inv  = i_neg;
            end
            dsrm_pkg::MODE_VOLUME:  begin
                opnd = {{(32-NC){1'b0}}, i_cb};
                inv  = i_neg;
            end
            default:                opnd = 32'd0;
        endcase
        n_prod = {32'd0, i_scale} * {32'd0, opnd};
    end

    always_comb begin
        shifted = r_prod >> FRAC_BITS;
        sat     = |shifted[63:32];
        res     = sat ? 32'hFFFF_FFFF : shifted[31:0];
        if (r_inv)
            res = i_min;
        if (res < i_min)
            res = i_min;
        if (res > i_max)
            res = i_max;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_inv    <= inv;
            r_radius <= res;
            r_oinv   <= r_inv;
        end
    end

    assign o_radius = r_radius;
    assign o_inv    = r_oinv;

endmodule

// ----- hw/rtl/data_to_sphere_radius_mapper.sv -----
`timescale 1ns / 1ps
// channel | dir | valid/ready           | payload
// s_axis  | in  | i_tvalid / o_tready   | i_tdata: data_value
// m_axis  | out | o_tvalid / i_tready   | o_tdata: radius, o_tuser: invalid
// cfg     | in  | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One word per cycle while the output is not stalled. There are max(NS, NC) cells, one per root
// digit (NS = (32+F)/2 square root digits, NC = (33+2F)/3 cube root digits),
// then the multiply stage and the clamp stage feeding the output register.
// Synchronous active-low reset clears the valid chain and sets the config registers to their defaults.
// A stalled output freezes the whole chain; o_tready follows it.
module data_to_sphere_radius_mapper #(
    parameter int FRAC_BITS = dsrm_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [31:0] i_tdata,   // [31:0] data_value
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,   // [31:0] radius
    output logic        o_tuser,   // [0] invalid
    input  logic        i_cfg_we,
    input  logic [dsrm_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsrm_pkg::REG_W-1:0]     i_cfg_data
);

    localparam int NS = (32 + FRAC_BITS) / 2;
    localparam int NC = (33 + 2 * FRAC_BITS) / 3;
    localparam int D  = (NS > NC) ? NS : NC;
    localparam int V  = D + 2;

    dsrm_pkg::t_mode r_mode;
    logic [31:0]     r_scale, r_min, r_max;
    logic [V-1:0]    r_vld;
    logic            en;

    logic              c_neg [0:D];
    logic [30:0]       c_mag [0:D];
    logic [2*NS-1:0]   c_xs  [0:D];
    logic [NS-1:0]     c_ys  [0:D];
    logic [NS+1:0]     c_rs  [0:D];
    logic [3*NC-1:0]   c_xc  [0:D];
    logic [NC-1:0]     c_yc  [0:D];
    logic [2*NC-1:0]   c_sc  [0:D];
    logic [2*NC+3:0]   c_rc  [0:D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= dsrm_pkg::MODE_FIXED;
            r_scale <= dsrm_pkg::SCALE_RST;
            r_min   <= dsrm_pkg::MIN_RST;
            r_max   <= dsrm_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dsrm_pkg::REG_MAP_MODE:   r_mode  <= dsrm_pkg::t_mode'(i_cfg_data[1:0]);
                dsrm_pkg::REG_SCALE:      r_scale <= i_cfg_data;
                dsrm_pkg::REG_MIN_RADIUS: r_min   <= i_cfg_data;
                dsrm_pkg::REG_MAX_RADIUS: r_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !r_vld[V-1] || i_tready;
    assign o_tready = en;
    assign o_tvalid = r_vld[V-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[V-2:0], i_tvalid};
        end
    end

    assign c_neg[0] = i_tdata[31];
    assign c_mag[0] = i_tdata[30:0];
    assign c_xs[0]  = {{(2*NS-31-FRAC_BITS){1'b0}}, i_tdata[30:0], {FRAC_BITS{1'b0}}};
    assign c_ys[0]  = '0;
    assign c_rs[0]  = '0;
    assign c_xc[0]  = {{(3*NC-31-2*FRAC_BITS){1'b0}}, i_tdata[30:0],
                       {(2*FRAC_BITS){1'b0}}};
    assign c_yc[0]  = '0;
    assign c_sc[0]  = '0;
    assign c_rc[0]  = '0;

    for (genvar k = 0; k < D; k++) begin : g_cell
        dsrm_cell #(
            .NS    (NS),
            .NC    (NC),
            .DO_SQ (k < NS),
            .DO_CB (k < NC)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_neg (c_neg[k]),
            .i_mag (c_mag[k]),
            .i_xs  (c_xs[k]),
            .i_ys  (c_ys[k]),
            .i_rs  (c_rs[k]),
            .i_xc  (c_xc[k]),
            .i_yc  (c_yc[k]),
            .i_sc  (c_sc[k]),
            .i_rc  (c_rc[k]),
            .o_neg (c_neg[k+1]),
            .o_mag (c_mag[k+1]),
            .o_xs  (c_xs[k+1]),
            .o_ys  (c_ys[k+1]),
            .o_rs  (c_rs[k+1]),
            .o_xc  (c_xc[k+1]),
            .o_yc  (c_yc[k+1]),
            .o_sc  (c_sc[k+1]),
            .o_rc  (c_rc[k+1])
        );
    end

    dsrm_post #(
        .FRAC_BITS (FRAC_BITS),
        .NS        (NS),
        .NC        (NC)
    ) u_post (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_mode   (r_mode),
        .i_scale  (r_scale),
        .i_min    (r_min),
        .i_max    (r_max),
        .i_neg    (c_neg[D]),
        .i_mag    (c_mag[D]),
        .i_sq     (c_ys[D]),
        .i_cb     (c_yc[D]),
        .o_radius (o_tdata),
        .o_inv    (o_tuser)
    );

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !i_tready |=> o_tvalid)
        else $error("result word dropped while stalled");
    a_inv_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_tuser |->
            (r_mode == dsrm_pkg::MODE_SURFACE || r_mode == dsrm_pkg::MODE_VOLUME))
        else $error("invalid flag outside root mode");
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> o_tdata <= r_max)
        else $error("radius above max clamp");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_tvalid |-> o_tready)
        else $error("chain stalled with empty output");
`endif

endmodule
